// ----- design/dent_pkg.sv -----
// ---------------------------------------------------------------------------
// dent_pkg
// Shared types, codes and helpers for the directory entry table.
// ---------------------------------------------------------------------------
package dent_pkg;

   // Default sizing
   localparam int SLOTS_DEF      = 32;
   localparam int INODE_BITS_DEF = 16;

   // Fixed field widths
   localparam int NAME_W   = 32;
   localparam int IN_INO_W = 16;
   localparam int OUT_IDX_W = 5;

   // Operation codes
   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_REWIND = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADNAME  = 3'd1,
      ST_EXISTS   = 3'd2,
      ST_NOSPACE  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_END      = 3'd5
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // A name is bad if its first byte is zero or a nonzero byte follows a zero byte
   function automatic logic name_is_bad(input logic [NAME_W-1:0] nm);
      logic seen_zero;
      logic bad;
      seen_zero = 1'b0;
      bad       = (nm[7:0] == 8'd0);
      for (int b = 0; b < 4; b++) begin
         if (nm[8*b +: 8] == 8'd0) begin
            seen_zero = 1'b1;
         end else if (seen_zero) begin
            bad = 1'b1;
         end
      end
      return bad;
   endfunction

endpackage

// ----- design/directory_entry_table_core.sv -----
// ---------------------------------------------------------------------------
// directory_entry_table_core
// Table of directory slots (name + inode) held in one synchronous memory.
// Create, delete and read-next run as a pipelined slot scan; rewind only resets the read cursor.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  request   start / busy          req_op, req_entry_name, req_inode_number
//  response  rsp_valid (strobe)    rsp_status, rsp_found_name,
//                                  rsp_found_inode, rsp_slot_index
//
// Rewind and bad-name requests answer in the cycle after the transfer.
// Create, delete and read-next scan the slot memory one read per cycle
// through its registered read port, and each scan stops early at its hit
// (for create, a slot that holds the same name). busy stays high while a
// scan runs; the result strobe cannot be held off by the receiver. Reset
// (synchronous) frees every slot at once through per-slot valid bits and
// zeroes the read cursor.
// ---------------------------------------------------------------------------
module directory_entry_table_core #(
   parameter int SLOTS      = dent_pkg::SLOTS_DEF,
   parameter int INODE_BITS = dent_pkg::INODE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [dent_pkg::NAME_W-1:0]      req_entry_name,
   input  logic [dent_pkg::IN_INO_W-1:0]    req_inode_number,
   // response
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [dent_pkg::NAME_W-1:0]      rsp_found_name,
   output logic [dent_pkg::IN_INO_W-1:0]    rsp_found_inode,
   output logic [dent_pkg::OUT_IDX_W-1:0]   rsp_slot_index
);

   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int NW    = dent_pkg::NAME_W;
   localparam int EW    = NW + INODE_BITS;
   localparam int OIW   = dent_pkg::IN_INO_W;
   localparam int XW    = dent_pkg::OUT_IDX_W;

   // Slot memory: {name, inode}
   logic [EW-1:0]          entry_mem [SLOTS];
   logic [SLOTS-1:0]       valid_ff;

   // Sequencer and request capture
   dent_pkg::state_type    state_ff, state_in;
   dent_pkg::op_type       op_ff, op_in;
   logic [NW-1:0]          name_ff, name_in;
   logic [INODE_BITS-1:0]  inode_ff, inode_in;
   logic [CW-1:0]          cursor_ff, cursor_in;

   // Scan pipeline
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          eval_ff, eval_in;
   logic                   free_hit_ff, free_hit_in;
   logic [AW-1:0]          free_idx_ff, free_idx_in;
   logic [EW-1:0]          rd_data_ff;
   logic                   rd_valid_ff;

   // Response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   dent_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [NW-1:0]          rsp_name_ff, rsp_name_in;
   logic [OIW-1:0]         rsp_inode_ff, rsp_inode_in;
   logic [XW-1:0]          rsp_slot_ff, rsp_slot_in;

   // Memory and valid-bit controls
   logic                   rd_en;
   logic                   mem_we;
   logic                   clr_valid;

   // Scan evaluation
   logic                   req_bad;
   logic                   issue_more;
   logic [NW-1:0]          rd_name;
   logic [INODE_BITS-1:0]  rd_inode;
   logic                   slot_used;
   logic                   slot_match;
   logic                   scan_hit;
   logic                   scan_exhausted;
   logic                   scan_done;
   logic                   need_scan;

   assign req_bad        = dent_pkg::name_is_bad(req_entry_name);
   assign issue_more     = (issue_ff != CW'(SLOTS));
   assign rd_name        = rd_data_ff[EW-1 -: NW];
   assign rd_inode       = rd_data_ff[INODE_BITS-1:0];
   assign slot_used      = pend_ff && rd_valid_ff && (rd_name[7:0] != 8'd0);
   assign slot_match     = slot_used && (rd_name == name_ff);
   assign scan_hit       = (op_ff == dent_pkg::OP_READ) ? slot_used : slot_match;
   assign scan_exhausted = !pend_ff && !issue_more;
   assign scan_done      = scan_hit || scan_exhausted;
   assign need_scan      = (dent_pkg::op_type'(req_op) == dent_pkg::OP_READ) ||
                           (((dent_pkg::op_type'(req_op) == dent_pkg::OP_CREATE) ||
                             (dent_pkg::op_type'(req_op) == dent_pkg::OP_DELETE)) &&
                            !req_bad);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dent_pkg::S_IDLE: begin
            if (start && need_scan) begin
               state_in = dent_pkg::S_SCAN;
            end
         end
         dent_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = dent_pkg::S_IDLE;
            end
         end
         default: state_in = dent_pkg::S_IDLE;
      endcase
   end

   // Datapath and response control
   always_comb begin
      op_in         = op_ff;
      name_in       = name_ff;
      inode_in      = inode_ff;
      cursor_in     = cursor_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      eval_in       = eval_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = dent_pkg::ST_OK;
      rsp_name_in   = '0;
      rsp_inode_in  = '0;
      rsp_slot_in   = '0;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      clr_valid     = 1'b0;

      unique case (state_ff)
         dent_pkg::S_IDLE: begin
            if (start) begin
               op_in       = dent_pkg::op_type'(req_op);
               name_in     = req_entry_name;
               inode_in    = INODE_BITS'(req_inode_number);
               free_hit_in = 1'b0;
               unique case (dent_pkg::op_type'(req_op))
                  dent_pkg::OP_REWIND: begin
                     cursor_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  dent_pkg::OP_READ: begin
                     issue_in = cursor_ff;
                  end
                  dent_pkg::OP_CREATE, dent_pkg::OP_DELETE: begin
                     issue_in = '0;
                     if (req_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = dent_pkg::ST_BADNAME;
                     end
                  end
                  default: ;
               endcase
            end
         end

         dent_pkg::S_SCAN: begin
            // issue one read per cycle until the last slot has been issued
            if (issue_more) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
               eval_in  = issue_ff[AW-1:0];
            end

            // lowest free slot for create
            if (pend_ff && !slot_used && !free_hit_ff) begin
               free_hit_in = 1'b1;
               free_idx_in = eval_ff;
            end

            if (scan_hit) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  dent_pkg::OP_READ: begin
                     cursor_in    = CW'(eval_ff) + CW'(1);
                     rsp_name_in  = rd_name;
                     rsp_inode_in = OIW'(rd_inode);
                     rsp_slot_in  = XW'(eval_ff);
                  end
                  dent_pkg::OP_DELETE: begin
                     clr_valid    = 1'b1;
                     rsp_inode_in = OIW'(rd_inode);
                     rsp_slot_in  = XW'(eval_ff);
                  end
                  dent_pkg::OP_CREATE: begin
                     rsp_status_in = dent_pkg::ST_EXISTS;
                  end
                  default: ;
               endcase
            end else if (scan_exhausted) begin
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  dent_pkg::OP_READ: begin
                     cursor_in     = CW'(SLOTS);
                     rsp_status_in = dent_pkg::ST_END;
                  end
                  dent_pkg::OP_DELETE: begin
                     rsp_status_in = dent_pkg::ST_NOTFOUND;
                  end
                  dent_pkg::OP_CREATE: begin
                     if (free_hit_ff) begin
                        mem_we      = 1'b1;
                        rsp_slot_in = XW'(free_idx_ff);
                     end else begin
                        rsp_status_in = dent_pkg::ST_NOSPACE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         default: ;
      endcase
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[free_idx_ff] <= {name_ff, inode_ff};
      end
      if (rd_en) begin
         rd_data_ff  <= entry_mem[issue_ff[AW-1:0]];
         rd_valid_ff <= valid_ff[issue_ff[AW-1:0]];
      end
   end

   // Per-slot valid bits; a slot never written or deleted reads as free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (mem_we) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (clr_valid) begin
            valid_ff[eval_ff] <= 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dent_pkg::S_IDLE;
         cursor_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      name_ff       <= name_in;
      inode_ff      <= inode_in;
      issue_ff      <= issue_in;
      eval_ff       <= eval_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_inode_ff  <= rsp_inode_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Ports
   assign busy            = (state_ff != dent_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_name  = rsp_name_ff;
   assign rsp_found_inode = rsp_inode_ff;
   assign rsp_slot_index  = rsp_slot_ff;

endmodule
